[design/sfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_pkg
// shared types, constants and helpers of the screen fade sequencer
// ----------------------------------------------------------------------------
package sfs_pkg;

    // fixed point level format, full scale is all ones
    localparam int LEVEL_BITS = 16;
    localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = '1;

    // payload widths
    localparam int OP_W    = 2;
    localparam int DELTA_W = 10;
    localparam int RATE_W  = 16;
    localparam int HOLD_W  = 16;
    localparam int TINT_W  = 32;
    localparam int PHASE_W = 2;
    localparam int LEVEL_OUT_W = 16;

    // rate * delta product and the compare width that holds it and a level
    localparam int STEP_W = RATE_W + DELTA_W;
    localparam int CMP_W  = (LEVEL_BITS > STEP_W) ? LEVEL_BITS : STEP_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_FADE_OUT = 2'd1;
    localparam logic [OP_W-1:0] OP_FADE_IN  = 2'd2;

    // reported phase codes
    localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_IN   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_OUT  = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_HOLD = 2'd3;

    // reset values
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd98;
    localparam logic [TINT_W-1:0] TINT_RESET = 32'hFF00_0000;

    // internal sequencer state, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_IN   = 4'b0010,
        ST_OUT  = 4'b0100,
        ST_HOLD = 4'b1000
    } phase_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            ST_IN:   code = PHASE_IN;
            ST_OUT:  code = PHASE_OUT;
            ST_HOLD: code = PHASE_HOLD;
            default: code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

[design/sfs_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_cmd_if
// command channel: ticks and fade start commands
// ----------------------------------------------------------------------------
interface sfs_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [sfs_pkg::OP_W-1:0]     operation;
    logic [sfs_pkg::DELTA_W-1:0]  delta_ms;
    logic [sfs_pkg::RATE_W-1:0]   new_rate;
    logic [sfs_pkg::HOLD_W-1:0]   new_hold_ms;
    logic                         new_auto_reverse;
    logic [sfs_pkg::TINT_W-1:0]   new_tint;

    modport source (
        output valid, operation, delta_ms, new_rate, new_hold_ms,
               new_auto_reverse, new_tint,
        input  ready
    );
    modport sink (
        input  valid, operation, delta_ms, new_rate, new_hold_ms,
               new_auto_reverse, new_tint,
        output ready
    );
endinterface
`default_nettype wire

[design/sfs_status_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_status_if
// status channel: phase, level, tint and overlay word
// ----------------------------------------------------------------------------
interface sfs_status_if;
    logic                             valid;
    logic                             ready;
    logic [sfs_pkg::PHASE_W-1:0]      phase_out;
    logic [sfs_pkg::LEVEL_OUT_W-1:0]  level_out;
    logic                             fading;
    logic [sfs_pkg::TINT_W-1:0]       tint_out;
    logic [sfs_pkg::TINT_W-1:0]       overlay_word;

    modport source (
        output valid, phase_out, level_out, fading, tint_out, overlay_word,
        input  ready
    );
    modport sink (
        input  valid, phase_out, level_out, fading, tint_out, overlay_word,
        output ready
    );
endinterface
`default_nettype wire

[design/screen_fade_sequencer.sv]
// the status transaction of an accepted command is registered and offered in the next cycle
// throughput: one command per cycle while status takes each transaction, set by the single rate * delta multiply-add
// and phase update that sit between the state registers and the status register
// a new command is taken while the status register is empty or being drained
// reset (rst_n low, asynchronous): idle, level 0, rate 98, hold 0, tint opaque black
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// screen_fade_sequencer
// fade-out / hold / fade-in sequencer for a display overlay, one status
// transaction for every command transaction
// ----------------------------------------------------------------------------
module screen_fade_sequencer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sfs_cmd_if.sink     cmd,
    sfs_status_if.source status
);

    // ------------------------------------------------------------------
    // architectural state
    // ------------------------------------------------------------------
    sfs_pkg::phase_t                    phase_reg, phase_next;
    logic [sfs_pkg::LEVEL_BITS-1:0]     level_reg, level_next;
    logic [sfs_pkg::RATE_W-1:0]         rate_reg, rate_next;
    logic [sfs_pkg::HOLD_W-1:0]         hold_left_reg, hold_left_next;
    logic                               reverse_after_reg, reverse_after_next;
    logic [sfs_pkg::TINT_W-1:0]         tint_reg, tint_next;

    // status output register
    logic                               out_valid_reg;
    logic [sfs_pkg::PHASE_W-1:0]        phase_out_reg;
    logic [sfs_pkg::LEVEL_OUT_W-1:0]    level_out_reg;
    logic                               fading_reg;
    logic [sfs_pkg::TINT_W-1:0]         tint_out_reg;
    logic [sfs_pkg::TINT_W-1:0]         overlay_reg;

    logic                               cmd_accept;
    logic                               out_take;

    // tick arithmetic
    logic [sfs_pkg::STEP_W-1:0]         step;
    logic [sfs_pkg::CMP_W-1:0]          step_ext;
    logic [sfs_pkg::CMP_W-1:0]          headroom;
    logic [sfs_pkg::CMP_W-1:0]          level_ext;
    logic                               reach_full;
    logic                               reach_zero;
    logic                               hold_done;
    sfs_pkg::phase_t                    after_full;

    // ------------------------------------------------------------------
    // handshake: the status register frees up in the same cycle it drains
    // ------------------------------------------------------------------
    assign out_take   = out_valid_reg && status.ready;
    assign cmd.ready  = !out_valid_reg || status.ready;
    assign cmd_accept = cmd.valid && cmd.ready;

    // ------------------------------------------------------------------
    // tick datapath: 16x10 multiply, then saturating compare both ways
    // ------------------------------------------------------------------
    assign step      = sfs_pkg::STEP_W'(rate_reg) * sfs_pkg::STEP_W'(cmd.delta_ms);
    assign step_ext  = sfs_pkg::CMP_W'(step);
    assign level_ext = sfs_pkg::CMP_W'(level_reg);
    assign headroom  = sfs_pkg::CMP_W'(sfs_pkg::FULL_LEVEL - level_reg);

    assign reach_full = (step_ext >= headroom);
    assign reach_zero = (step_ext >= level_ext);
    assign hold_done  = (sfs_pkg::HOLD_W'(cmd.delta_ms) >= hold_left_reg);

    // what follows full level once any hold is over
    assign after_full = reverse_after_reg ? sfs_pkg::ST_IN : sfs_pkg::ST_IDLE;

    // ------------------------------------------------------------------
    // next state for the command at the input
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next         = phase_reg;
        level_next         = level_reg;
        rate_next          = rate_reg;
        hold_left_next     = hold_left_reg;
        reverse_after_next = reverse_after_reg;
        tint_next          = tint_reg;

        case (cmd.operation)
            sfs_pkg::OP_TICK:
            begin
                case (phase_reg)
                    sfs_pkg::ST_OUT:
                    begin
                        if (reach_full)
                        begin
                            // leftover milliseconds of this tick are dropped
                            level_next = sfs_pkg::FULL_LEVEL;
                            phase_next = (hold_left_reg != '0) ? sfs_pkg::ST_HOLD
                                                               : after_full;
                        end
                        else
                        begin
                            level_next = level_reg + sfs_pkg::LEVEL_BITS'(step);
                        end
                    end
                    sfs_pkg::ST_HOLD:
                    begin
                        if (hold_done)
                        begin
                            hold_left_next = '0;
                            phase_next     = after_full;
                        end
                        else
                        begin
                            hold_left_next = hold_left_reg
                                           - sfs_pkg::HOLD_W'(cmd.delta_ms);
                        end
                    end
                    sfs_pkg::ST_IN:
                    begin
                        if (reach_zero)
                        begin
                            level_next = '0;
                            phase_next = sfs_pkg::ST_IDLE;
                        end
                        else
                        begin
                            level_next = level_reg - sfs_pkg::LEVEL_BITS'(step);
                        end
                    end
                    default:
                    begin
                        // idle tick leaves everything alone
                    end
                endcase
            end
            sfs_pkg::OP_FADE_OUT:
            begin
                phase_next         = sfs_pkg::ST_OUT;
                level_next         = '0;
                rate_next          = cmd.new_rate;
                hold_left_next     = cmd.new_hold_ms;
                reverse_after_next = cmd.new_auto_reverse;
                tint_next          = cmd.new_tint;
            end
            sfs_pkg::OP_FADE_IN:
            begin
                // hold time, reverse flag and tint stay as they were
                phase_next = sfs_pkg::ST_IN;
                level_next = sfs_pkg::FULL_LEVEL;
                rate_next  = cmd.new_rate;
            end
            default:
            begin
                // unused code only reports the current state
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state registers, updated on every accepted command
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= sfs_pkg::ST_IDLE;
            level_reg         <= '0;
            rate_reg          <= sfs_pkg::RATE_RESET;
            hold_left_reg     <= '0;
            reverse_after_reg <= 1'b0;
            tint_reg          <= sfs_pkg::TINT_RESET;
        end
        else if (cmd_accept)
        begin
            phase_reg         <= phase_next;
            level_reg         <= level_next;
            rate_reg          <= rate_next;
            hold_left_reg     <= hold_left_next;
            reverse_after_reg <= reverse_after_next;
            tint_reg          <= tint_next;
        end
    end

    // ------------------------------------------------------------------
    // status register: valid flag is control, the payload is not reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            phase_out_reg <= sfs_pkg::phase_code(phase_next);
            level_out_reg <= sfs_pkg::LEVEL_OUT_W'(level_next);
            fading_reg    <= (phase_next != sfs_pkg::ST_IDLE);
            tint_out_reg  <= tint_next;
            // top eight level bits are ORed into the alpha byte of the tint
            overlay_reg   <= tint_next
                           | {level_next[sfs_pkg::LEVEL_BITS-1 -: 8],
                              {(sfs_pkg::TINT_W-8){1'b0}}};
        end
    end

    assign status.valid        = out_valid_reg;
    assign status.phase_out    = phase_out_reg;
    assign status.level_out    = level_out_reg;
    assign status.fading       = fading_reg;
    assign status.tint_out     = tint_out_reg;
    assign status.overlay_word = overlay_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("sequencer phase register is not one-hot");

    a_hold_at_full: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sfs_pkg::ST_HOLD) |-> (level_reg == sfs_pkg::FULL_LEVEL))
        else $error("holding phase below full level");

    a_fade_in_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sfs_pkg::ST_IN) |-> (level_reg != '0))
        else $error("fading in with level already at zero");

    a_accept_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> out_valid_reg)
        else $error("accepted command produced no status transaction");

    a_fade_out_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && (cmd.operation == sfs_pkg::OP_FADE_OUT))
        |=> ((status.phase_out == sfs_pkg::PHASE_OUT) && (status.level_out == '0)))
        else $error("fade out start not reported as fading out at zero level");

endmodule
`default_nettype wire
